// File: design/sate_pkg.sv
// ----------------------------------------------------------------------------
// Sorted array table engine package
// Shared constants and types for the cell row and its control.
// ----------------------------------------------------------------------------
package sate_pkg;

	localparam int Capacity   = 64;
	localparam int EntryWidth = 32;
	localparam int IdxW       = $clog2(Capacity);
	localparam int CntW       = $clog2(Capacity + 1);

	typedef enum logic [3:0] {
		OP_INSERT      = 4'd0,
		OP_INSERT_AT   = 4'd1,
		OP_DELETE_LAST = 4'd2,
		OP_DELETE_AT   = 4'd3,
		OP_READ        = 4'd4,
		OP_FIND_FIRST  = 4'd5,
		OP_FIND_LAST   = 4'd6,
		OP_MIN         = 4'd7,
		OP_MAX         = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_FULL     = 3'd2,
		ST_BADPOS   = 3'd3,
		ST_SORTED   = 3'd4,
		ST_NOTFOUND = 3'd5
	} status_t;

	// Row command: all cells act on it in the same cycle
	typedef struct packed {
		logic                  open_en;  // shift right from at, write key there
		logic                  close_en; // shift left from at
		logic [IdxW-1:0]       at;
		logic [EntryWidth-1:0] key;
	} row_cmd_t;

	// Per-cell flags handed back to control
	typedef struct packed {
		logic [Capacity-1:0] le;  // key >= entry
		logic [Capacity-1:0] eq;  // key == entry
	} row_flags_t;

endpackage

// File: design/sorted_array_table_engine_top.sv
// ----------------------------------------------------------------------------
// Sorted array table engine, top level
// Operation sequencer around a row of table cells.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one operation per word: opcode, value and position.
//   m_axis returns one result per operation: status, index, entry, count.
//   cfg writes sorted_mode; only write it while the engine is idle.
// Timing:
//   An operation passes through capture, compare in all cells, a reduction
//   pass over the registered cell flags, then the row update and result
//   load before the next accept. The result word is registered in the done
//   state. Min and max walk the cells with a single comparator during the
//   reduction step, which stays in that step until the walk ends.
//   One operation is in flight at a time; s_axis_tready is high in idle.
// Reset:
//   arst_n clears the count, the mode and all handshake state. Table cells
//   hold no reset; slots at or above the count are never reported.
// Stall:
//   A result waits in the output register while m_axis_tready is low; the
//   next operation is accepted and computed, then waits (row update too)
//   until the register frees up.
// ----------------------------------------------------------------------------
module sorted_array_table_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // operation[3:0], value[35:4], position[41:36]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // status[2:0], index[8:3], entry_out[40:9], count[47:41]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);
	import sate_pkg::*;

	typedef enum logic [1:0] {S_IDLE, S_CMP, S_RED, S_DONE} state_t;

	state_t                state_q;
	logic                  mode_q;
	logic [CntW-1:0]       count_q;
	logic [3:0]            op_q;
	logic [EntryWidth-1:0] key_q;
	logic [IdxW-1:0]       pos_q;
	row_cmd_t              cmd;
	row_flags_t            flags;
	logic [Capacity-1:0][EntryWidth-1:0] entries;
	logic [Capacity-1:0]   le_s1, eq_s1;
	logic [IdxW-1:0]       mm_idx_q;
	logic [CntW-1:0]       mm_k_q;
	logic                  out_valid_q;
	logic [47:0]           out_data_q;
	// reduction results
	logic [CntW-1:0]       ins_idx;
	logic                  hit_first, hit_last;
	logic [IdxW-1:0]       first_idx, last_idx;
	logic [IdxW-1:0]       idx_s2;
	logic [CntW-1:0]       ins_idx_s2;
	logic                  hit_s2;
	// final
	status_t               st;
	logic [IdxW-1:0]       res_idx;
	logic [EntryWidth-1:0] res_eo;
	logic [CntW-1:0]       new_count;
	logic                  do_open, do_close;
	logic [IdxW-1:0]       at;
	logic                  empty, full;
	logic                  res_load;

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = (state_q == S_IDLE) && !out_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign empty = (count_q == '0);
	assign full  = (count_q >= CntW'(Capacity));

	// Result register free (or draining this cycle) while an operation is done
	assign res_load = (state_q == S_DONE) && (!out_valid_q || m_axis_tready);

	// Flag reduction over cells below the count
	always_comb begin
		ins_idx   = '0;
		hit_first = 1'b0;
		hit_last  = 1'b0;
		first_idx = '0;
		last_idx  = '0;
		for (int i = 0; i < Capacity; i++) begin
			if (CntW'(i) < count_q) begin
				if (le_s1[i]) ins_idx = CntW'(i + 1);
				if (eq_s1[i]) begin
					last_idx = IdxW'(i);
					hit_last = 1'b1;
				end
			end
			if (CntW'(Capacity-1-i) < count_q && eq_s1[Capacity-1-i]) begin
				first_idx = IdxW'(Capacity-1-i);
				hit_first = 1'b1;
			end
		end
	end

	// Result and row command
	always_comb begin
		st        = ST_OK;
		res_idx   = '0;
		res_eo    = '0;
		new_count = count_q;
		do_open   = 1'b0;
		do_close  = 1'b0;
		at        = '0;
		case (op_q)
			OP_INSERT: begin
				if (full) st = ST_FULL;
				else begin
					at = mode_q ? ins_idx_s2[IdxW-1:0] : count_q[IdxW-1:0];
					res_idx = at;
					do_open = 1'b1;
					new_count = count_q + 1'b1;
				end
			end
			OP_INSERT_AT: begin
				if (mode_q) st = ST_SORTED;
				else if (CntW'(pos_q) > count_q) st = ST_BADPOS;
				else if (full) st = ST_FULL;
				else begin
					at = pos_q;
					res_idx = at;
					do_open = 1'b1;
					new_count = count_q + 1'b1;
				end
			end
			OP_DELETE_LAST: begin
				if (empty) st = ST_EMPTY;
				else begin
					res_idx = IdxW'(count_q - 1'b1);
					res_eo = entries[res_idx];
					new_count = count_q - 1'b1;
				end
			end
			OP_DELETE_AT: begin
				if (empty) st = ST_EMPTY;
				else if (mode_q) st = ST_SORTED;
				else if (CntW'(pos_q) >= count_q) st = ST_BADPOS;
				else begin
					at = pos_q;
					res_idx = pos_q;
					res_eo = entries[pos_q];
					do_close = 1'b1;
					new_count = count_q - 1'b1;
				end
			end
			OP_READ: begin
				if (empty) st = ST_EMPTY;
				else if (CntW'(pos_q) >= count_q) st = ST_BADPOS;
				else begin
					res_idx = pos_q;
					res_eo = entries[pos_q];
				end
			end
			OP_FIND_FIRST, OP_FIND_LAST, OP_MIN, OP_MAX: begin
				if (empty) st = ST_EMPTY;
				else if (!hit_s2) st = ST_NOTFOUND;
				else begin
					res_idx = idx_s2;
					res_eo = entries[idx_s2];
				end
			end
			default: ;
		endcase
	end

	assign cmd.open_en  = res_load && do_open;
	assign cmd.close_en = res_load && do_close;
	assign cmd.at       = at;
	assign cmd.key      = key_q;

	sate_row u_row (
		.clk     (clk),
		.cmd     (cmd),
		.flags   (flags),
		.entries (entries)
	);

	// Min/max scan: one cell per cycle with a single comparator
	logic mm_op, mm_better;
	assign mm_op = (op_q == OP_MIN) || (op_q == OP_MAX);
	assign mm_better = (op_q == OP_MIN) ? (entries[mm_k_q[IdxW-1:0]] < entries[mm_idx_q])
	                                    : (entries[mm_k_q[IdxW-1:0]] > entries[mm_idx_q]);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cfg_valid && cfg_ready) mode_q <= cfg_data;
					if (s_axis_tvalid) begin
						op_q    <= s_axis_tdata[3:0];
						key_q   <= s_axis_tdata[35:4];
						pos_q   <= s_axis_tdata[41:36];
						mm_idx_q <= '0;
						mm_k_q  <= CntW'(1);
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					le_s1   <= flags.le;
					eq_s1   <= flags.eq;
					state_q <= S_RED;
				end
				S_RED: begin
					if (mm_op && mm_k_q < count_q) begin
						if (mm_better) mm_idx_q <= mm_k_q[IdxW-1:0];
						mm_k_q <= mm_k_q + 1'b1;
					end else begin
						ins_idx_s2 <= ins_idx;
						hit_s2 <= mm_op ? 1'b1 : (op_q == OP_FIND_LAST ? hit_last : hit_first);
						idx_s2 <= mm_op ? mm_idx_q
						          : (op_q == OP_FIND_LAST ? last_idx : first_idx);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_load) begin
						out_data_q  <= {new_count, res_eo, res_idx, st};
						count_q     <= new_count;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// The row is only shifted when the result register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.open_en || cmd.close_en) |-> (state_q == S_DONE))
		else $error("row shift outside done state");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.open_en |-> !full)
		else $error("insert into full table");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.close_en |-> !empty)
		else $error("delete from empty table");
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Capacity))
		else $error("count beyond capacity");

endmodule

// File: design/sate_cell.sv
// ----------------------------------------------------------------------------
// Table cell
// Holds one entry; shifts with its neighbors and compares against the key.
// ----------------------------------------------------------------------------
module sate_cell (
	input  logic                           clk,
	input  logic [sate_pkg::IdxW-1:0]      slot,
	input  sate_pkg::row_cmd_t             cmd,
	input  logic [sate_pkg::EntryWidth-1:0] left_entry,
	input  logic [sate_pkg::EntryWidth-1:0] right_entry,
	output logic [sate_pkg::EntryWidth-1:0] entry,
	output logic                           le,
	output logic                           eq
);
	import sate_pkg::*;

	logic [EntryWidth-1:0] entry_q;

	// Shift or load
	always_ff @(posedge clk) begin
		if (cmd.open_en) begin
			if (slot == cmd.at) entry_q <= cmd.key;
			else if (slot > cmd.at) entry_q <= left_entry;
		end else if (cmd.close_en && slot >= cmd.at) begin
			entry_q <= right_entry;
		end
	end

	assign entry = entry_q;
	assign le    = cmd.key >= entry_q;
	assign eq    = cmd.key == entry_q;

endmodule

// File: design/sate_row.sv
// ----------------------------------------------------------------------------
// Cell row
// Chain of table cells; each cell sees its left and right neighbor.
// ----------------------------------------------------------------------------
module sate_row (
	input  logic                 clk,
	input  sate_pkg::row_cmd_t   cmd,
	output sate_pkg::row_flags_t flags,
	output logic [sate_pkg::Capacity-1:0][sate_pkg::EntryWidth-1:0] entries
);
	import sate_pkg::*;

	for (genvar i = 0; i < Capacity; i++) begin : g_cell
		logic [EntryWidth-1:0] lft, rgt;
		assign lft = (i == 0) ? '0 : entries[(i == 0) ? 0 : i-1];
		assign rgt = (i == Capacity-1) ? '0 : entries[(i == Capacity-1) ? i : i+1];
		sate_cell u_cell (
			.clk         (clk),
			.slot        (IdxW'(i)),
			.cmd         (cmd),
			.left_entry  (lft),
			.right_entry (rgt),
			.entry       (entries[i]),
			.le          (flags.le[i]),
			.eq          (flags.eq[i])
		);
	end

endmodule
